[src/thrust_table_interpolator_unit_defines.svh]
// assertion macros shared by the thrust table interpolator rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef THRUST_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH
`define THRUST_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// consequent must hold whenever the antecedent holds
`define TTI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tti implication check failed");

// condition must never hold
`define TTI_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tti forbidden condition seen");

`else

`define TTI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TTI_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[src/tti_pkg.sv]
// types, constants and table rom for the thrust table interpolator
// no dependencies; used by every module of the block
package tti_pkg;

   // table geometry
   localparam int unsigned TABLE_POINTS = 23;
   localparam int unsigned IDX_W        = $clog2(TABLE_POINTS);

   // field and datapath widths
   localparam int unsigned VEL_IN_W = 16;   // commanded velocity, Q4.12
   localparam int unsigned MAG_W    = 17;   // velocity magnitude incl. 32768
   localparam int unsigned VEL_W    = 15;   // table velocity breakpoints
   localparam int unsigned THR_W    = 16;   // table thrust values
   localparam int unsigned SEG_W    = 12;   // segment spans dv, df, dm
   localparam int unsigned QUO_W    = 12;   // interpolation quotient
   localparam int unsigned NUM_W    = 23;   // dm * df + dv / 2
   localparam int unsigned LIMIT_W  = 17;   // thrust limits
   localparam int unsigned OUT_W    = 18;   // thrust result, Q10.8

   // divider pipeline shape
   localparam int unsigned DIV_STEP   = 3;
   localparam int unsigned DIV_STAGES = QUO_W / DIV_STEP;

   // config register indexes
   localparam int unsigned CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORWARD_LIMIT = 1'b0,
      CSR_REVERSE_LIMIT = 1'b1
   } csr_index_type;

   localparam logic [LIMIT_W-1:0] FORWARD_LIMIT_RESET = 17'd64000;
   localparam logic [LIMIT_W-1:0] REVERSE_LIMIT_RESET = 17'd25600;

   // breakpoints, velocity in Q4.12
   localparam logic [VEL_W-1:0] VEL_TABLE [TABLE_POINTS] = '{
      15'd1114,  15'd2081,  15'd3088,  15'd4100,  15'd5128,  15'd6144,
      15'd7168,  15'd8192,  15'd9220,  15'd10248, 15'd12296, 15'd13300,
      15'd14332, 15'd15360, 15'd16388, 15'd17412, 15'd18432, 15'd19460,
      15'd20480, 15'd21500, 15'd22528, 15'd23552, 15'd24572
   };

   // thrust at each breakpoint, Q10.8
   localparam logic [THR_W-1:0] THR_TABLE [TABLE_POINTS] = '{
      16'd312,   16'd707,   16'd1238,  16'd1896,  16'd2694,  16'd3612,
      16'd4660,  16'd5837,  16'd7149,  16'd8587,  16'd11839, 16'd13624,
      16'd15576, 16'd17661, 16'd19871, 16'd22195, 16'd24640, 16'd27227,
      16'd29920, 16'd32750, 16'd35713, 16'd38796, 16'd41983
   };

   // per-item side information that rides along the pipeline
   typedef struct packed {
      logic             neg;
      logic             zero;
      logic             sat;
      logic [THR_W-1:0] f0;
   } side_type;

   // divider working word
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [SEG_W-1:0] dv;
   } div_type;

   // segment 0 runs from the origin to the first breakpoint
   function automatic logic [VEL_W-1:0] seg_v0(input logic [IDX_W-1:0] idx);
      if (idx == '0) return '0;
      return VEL_TABLE[idx - IDX_W'(1)];
   endfunction

   function automatic logic [THR_W-1:0] seg_f0(input logic [IDX_W-1:0] idx);
      if (idx == '0) return '0;
      return THR_TABLE[idx - IDX_W'(1)];
   endfunction

   function automatic logic [SEG_W-1:0] seg_dv(input logic [IDX_W-1:0] idx);
      return SEG_W'(VEL_TABLE[idx] - seg_v0(idx));
   endfunction

   function automatic logic [SEG_W-1:0] seg_df(input logic [IDX_W-1:0] idx);
      return SEG_W'(THR_TABLE[idx] - seg_f0(idx));
   endfunction

endpackage

[src/tti_locate.sv]
// segment search over the breakpoint rom: compare stage, then lookup stage
// depends on tti_pkg
module tti_locate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  logic [tti_pkg::MAG_W-1:0] mag_in,
   input  tti_pkg::side_type        side_in,
   output logic                     valid_out,
   output tti_pkg::side_type        side_out,
   output logic [tti_pkg::SEG_W-1:0] dm_out,
   output logic [tti_pkg::SEG_W-1:0] dv_out,
   output logic [tti_pkg::SEG_W-1:0] df_out
);
   import tti_pkg::*;

   logic [TABLE_POINTS-2:0] above;
   logic                    valid_b_ff;
   logic [IDX_W-1:0]        idx_b_ff, idx_b_in;
   logic [VEL_W-1:0]        mag_b_ff;
   side_type                side_b_ff, side_b_in;
   logic                    valid_c_ff;
   side_type                side_c_ff, side_c_in;
   logic [SEG_W-1:0]        dm_c_ff, dm_c_in;
   logic [SEG_W-1:0]        dv_c_ff, df_c_ff;

   // parallel breakpoint compares, segment index is the count passed
   always_comb begin
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
         above[i] = mag_in > MAG_W'(VEL_TABLE[i]);
      end
      idx_b_in      = IDX_W'($countones(above));
      side_b_in     = side_in;
      side_b_in.sat = mag_in >= MAG_W'(VEL_TABLE[TABLE_POINTS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_in;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_b_ff  <= idx_b_in;
      mag_b_ff  <= mag_in[VEL_W-1:0];
      side_b_ff <= side_b_in;
   end

   // segment lookup and offset into the segment
   always_comb begin
      side_c_in    = side_b_ff;
      side_c_in.f0 = seg_f0(idx_b_ff);
      dm_c_in      = SEG_W'(mag_b_ff - seg_v0(idx_b_ff));
   end

   always_ff @(posedge clock) begin
      side_c_ff <= side_c_in;
      dm_c_ff   <= dm_c_in;
      dv_c_ff   <= seg_dv(idx_b_ff);
      df_c_ff   <= seg_df(idx_b_ff);
   end

   assign valid_out = valid_c_ff;
   assign side_out  = side_c_ff;
   assign dm_out    = dm_c_ff;
   assign dv_out    = dv_c_ff;
   assign df_out    = df_c_ff;

endmodule

[src/tti_div_stage.sv]
// one register stage of the restoring divider, DIV_STEP quotient bits each
// depends on tti_pkg
module tti_div_stage #(
   parameter int unsigned TOP_BIT = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   input  tti_pkg::side_type side_in,
   input  tti_pkg::div_type  div_in,
   output logic              valid_out,
   output tti_pkg::side_type side_out,
   output tti_pkg::div_type  div_out
);
   import tti_pkg::*;

   logic              valid_ff;
   side_type          side_ff;
   div_type           div_ff, div_in_next;
   logic [NUM_W-1:0]  trial;

   // compare and subtract the shifted divisor, msb first
   always_comb begin
      div_in_next = div_in;
      trial       = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
         trial = NUM_W'(div_in.dv) << (TOP_BIT - k);
         if (div_in_next.rem >= trial) begin
            div_in_next.rem = div_in_next.rem - trial;
            div_in_next.quo = div_in_next.quo | (QUO_W'(1) << (TOP_BIT - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      div_ff  <= div_in_next;
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign div_out   = div_ff;

endmodule

[src/thrust_table_interpolator_unit.sv]
// Thrust table interpolator top level: velocity word in, thrust word out.
// Throughput: one word per cycle, busy is never raised; the 9-stage
// pipeline is magnitude, compare, lookup, multiply, 4 divide, output.
// Reset clears all pipeline valids and loads the limits to 250 N and 100 N;
// the receiver cannot stall the result strobe.
`include "thrust_table_interpolator_unit_defines.svh"

module thrust_table_interpolator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [tti_pkg::VEL_IN_W-1:0] req_commanded_velocity,
   output logic                                rsp_valid,
   output logic signed [tti_pkg::OUT_W-1:0]    rsp_thrust_force,
   input  logic                                csr_write_enable,
   input  logic [tti_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tti_pkg::LIMIT_W-1:0]         csr_write_data
);
   import tti_pkg::*;

   logic [LIMIT_W-1:0] forward_limit_ff, reverse_limit_ff;

   logic               accept;
   logic               valid_a_ff;
   logic [MAG_W-1:0]   mag_a_ff, mag_a_in;
   side_type           side_a_ff, side_a_in;

   logic               valid_c;
   side_type           side_c;
   logic [SEG_W-1:0]   dm_c, dv_c, df_c;

   logic               valid_d_ff;
   side_type           side_d_ff;
   div_type            div_d_ff, div_d_in;

   logic               valid_bus [DIV_STAGES+1];
   side_type           side_bus  [DIV_STAGES+1];
   div_type            div_bus   [DIV_STAGES+1];

   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_thrust_ff, rsp_thrust_in;
   logic [LIMIT_W-1:0] limit_sel, mag_sum, mag_out;
   side_type           side_end;

   logic               valid_end;
   div_type            div_end;
   logic               rem_below_dv;
   logic               vel_zero, vel_neg;
   logic               thrust_zero, thrust_nonpos;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         forward_limit_ff <= FORWARD_LIMIT_RESET;
         reverse_limit_ff <= REVERSE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FORWARD_LIMIT: forward_limit_ff <= csr_write_data;
            CSR_REVERSE_LIMIT: reverse_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // command handshake, a word is taken in every cycle that start is high
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // magnitude and sign
   always_comb begin
      side_a_in      = '0;
      side_a_in.neg  = req_commanded_velocity[VEL_IN_W-1];
      side_a_in.zero = (req_commanded_velocity == '0);
      if (side_a_in.neg) begin
         mag_a_in = MAG_W'(18'h10000 - {2'b00, $unsigned(req_commanded_velocity)});
      end else begin
         mag_a_in = {1'b0, $unsigned(req_commanded_velocity)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff  <= mag_a_in;
      side_a_ff <= side_a_in;
   end

   // segment search
   tti_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (valid_a_ff),
      .mag_in    (mag_a_ff),
      .side_in   (side_a_ff),
      .valid_out (valid_c),
      .side_out  (side_c),
      .dm_out    (dm_c),
      .dv_out    (dv_c),
      .df_out    (df_c)
   );

   // numerator with half divisor for round to nearest
   always_comb begin
      div_d_in.rem = NUM_W'((2*SEG_W)'(dm_c) * (2*SEG_W)'(df_c) + (2*SEG_W)'(dv_c >> 1));
      div_d_in.quo = '0;
      div_d_in.dv  = dv_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= valid_c;
      end
   end

   always_ff @(posedge clock) begin
      side_d_ff <= side_c;
      div_d_ff  <= div_d_in;
   end

   // divider pipeline
   assign valid_bus[0] = valid_d_ff;
   assign side_bus[0]  = side_d_ff;
   assign div_bus[0]   = div_d_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      tti_div_stage #(
         .TOP_BIT (QUO_W - 1 - s * DIV_STEP)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_bus[s]),
         .side_in   (side_bus[s]),
         .div_in    (div_bus[s]),
         .valid_out (valid_bus[s+1]),
         .side_out  (side_bus[s+1]),
         .div_out   (div_bus[s+1])
      );
   end

   assign valid_end = valid_bus[DIV_STAGES];
   assign div_end   = div_bus[DIV_STAGES];

   // offset add, zero force, limit clamp and sign restore
   always_comb begin
      side_end  = side_bus[DIV_STAGES];
      limit_sel = side_end.neg ? reverse_limit_ff : forward_limit_ff;
      mag_sum   = LIMIT_W'(side_end.f0) + LIMIT_W'(div_end.quo);
      if (side_end.zero) begin
         mag_out = '0;
      end else if (side_end.sat || (mag_sum > limit_sel)) begin
         mag_out = limit_sel;
      end else begin
         mag_out = mag_sum;
      end
      if (side_end.neg) begin
         rsp_thrust_in = OUT_W'(0) - OUT_W'(mag_out);
      end else begin
         rsp_thrust_in = OUT_W'(mag_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_end;
      end
   end

   always_ff @(posedge clock) begin
      rsp_thrust_ff <= rsp_thrust_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_thrust_force = $signed(rsp_thrust_ff);

   // terms watched by the checks
   assign rem_below_dv  = div_end.rem < NUM_W'(div_end.dv);
   assign vel_zero      = (req_commanded_velocity == '0);
   assign vel_neg       = req_commanded_velocity[VEL_IN_W-1];
   assign thrust_zero   = (rsp_thrust_force == '0);
   assign thrust_nonpos = rsp_thrust_force[OUT_W-1] || thrust_zero;

   // checks
   `TTI_ASSERT_IMPLIES(a_rsp_from_accept, clock, reset, rsp_valid, $past(accept, 9))
   `TTI_ASSERT_IMPLIES(a_offset_in_segment, clock, reset, valid_c && !side_c.sat, dm_c <= dv_c)
   `TTI_ASSERT_NEVER(a_div_remainder, clock, reset, valid_end && !side_end.sat && !rem_below_dv)
   `TTI_ASSERT_IMPLIES(a_zero_out, clock, reset, rsp_valid && $past(vel_zero, 9), thrust_zero)
   `TTI_ASSERT_IMPLIES(a_neg_out, clock, reset, rsp_valid && $past(vel_neg, 9), thrust_nonpos)

endmodule
